@@ rtl/dppcm_pkg.sv @@
// Types and constants shared by the ping-pong DMA channel manager.
`default_nettype none

package dppcm_pkg;

    localparam int ADJ_SHIFT       = 14;
    localparam int STATUS_CHANNELS = 8;
    localparam int CH_NUM_W        = 4;

    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_REQUEST  = 2'd2,
        OP_RELEASE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RC_OK       = 2'd0,
        RC_INVALID  = 2'd1,
        RC_BUSY     = 2'd2,
        RC_NOT_REQ  = 2'd3
    } code_t;

    typedef struct packed {
        op_t                 operation;
        logic [CH_NUM_W-1:0] channel_num;
        logic [31:0]         source_addr;
        logic [31:0]         dest_addr;
        logic [15:0]         byte_count;
        logic [15:0]         done_status;
        logic [7:0]          adjust_value;
        logic [31:0]         control_flags;
        logic                handler_given;
    } item_t;

    typedef struct packed {
        code_t       result_code;
        logic        descriptor_valid;
        logic        loaded_buffer;
        logic [31:0] out_source;
        logic [31:0] out_dest;
        logic [15:0] out_count;
        logic        control_valid;
        logic [31:0] control_word;
        logic [1:0]  free_buffers;
        logic [7:0]  notify_mask;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/dppcm_if.sv @@
// Command and response channel interfaces of the ping-pong DMA channel manager.
`default_nettype none

interface dppcm_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  channel_num;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] byte_count;
    logic [15:0] done_status;
    logic [7:0]  adjust_value;
    logic [31:0] control_flags;
    logic        handler_given;

    modport source (
        output valid, operation, channel_num, source_addr, dest_addr, byte_count,
               done_status, adjust_value, control_flags, handler_given,
        input  ready
    );
    modport sink (
        input  valid, operation, channel_num, source_addr, dest_addr, byte_count,
               done_status, adjust_value, control_flags, handler_given,
        output ready
    );
endinterface

interface dppcm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_code;
    logic        descriptor_valid;
    logic        loaded_buffer;
    logic [31:0] out_source;
    logic [31:0] out_dest;
    logic [15:0] out_count;
    logic        control_valid;
    logic [31:0] control_word;
    logic [1:0]  free_buffers;
    logic [7:0]  notify_mask;

    modport source (
        output valid, result_code, descriptor_valid, loaded_buffer, out_source,
               out_dest, out_count, control_valid, control_word, free_buffers,
               notify_mask,
        input  ready
    );
    modport sink (
        input  valid, result_code, descriptor_valid, loaded_buffer, out_source,
               out_dest, out_count, control_valid, control_word, free_buffers,
               notify_mask,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/dppcm_in_stage.sv @@
// Input register stage that holds one command beat until the engine takes it.
`default_nettype none

module dppcm_in_stage
    import dppcm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cmd_valid,
    output logic       cmd_ready,
    input  wire item_t cmd_item,
    input  wire logic  take,
    output logic       fire,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign fire      = valid_reg && take;
    assign cmd_ready = !valid_reg || take;
    assign item      = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd_valid && cmd_ready)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            item_reg <= cmd_item;
        end
    end

    // A held beat may only be replaced once the engine has consumed it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !take) |=> (valid_reg && $stable(item_reg)))
        else $error("Held command beat was lost or overwritten.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> valid_reg)
        else $error("Accepted command beat did not reach the input register.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> cmd_ready)
        else $error("Empty input register refused a command beat.");

endmodule

`default_nettype wire

@@ rtl/dppcm_engine.sv @@
// Channel state registers and the single-pass update and result logic.
`default_nettype none

module dppcm_engine
    import dppcm_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire item_t item,
    output result_t    res
);

    logic [NUM_CHANNELS-1:0] claimed_reg, claimed_next;
    logic [NUM_CHANNELS-1:0] handler_reg, handler_next;
    logic [NUM_CHANNELS-1:0] next_b_reg, next_b_next;
    logic [NUM_CHANNELS-1:0] run_a_reg, run_a_next;
    logic [NUM_CHANNELS-1:0] run_b_reg, run_b_next;

    logic [NUM_CHANNELS-1:0] sel;
    logic [NUM_CHANNELS-1:0] done_a;
    logic [NUM_CHANNELS-1:0] done_b;
    logic [NUM_CHANNELS-1:0] notify_vec;
    logic [7:0]              notify_w;

    logic ch_valid;
    logic claimed_sel;
    logic next_b_sel;
    logic busy_sel;
    logic do_load;
    logic do_claim;
    logic do_release;
    logic do_complete;
    logic free_claimed;
    logic free_a;
    logic free_b;

    for (genvar g = 0; g < NUM_CHANNELS; g++)
    begin : g_chan
        assign sel[g] = (item.channel_num == CH_NUM_W'(g));
        if (g < STATUS_CHANNELS)
        begin : g_status
            assign done_a[g] = item.done_status[2*g];
            assign done_b[g] = item.done_status[2*g+1];
        end
        else
        begin : g_no_status
            assign done_a[g] = 1'b0;
            assign done_b[g] = 1'b0;
        end
    end

    assign notify_vec = (done_a | done_b) & handler_reg;

    for (genvar j = 0; j < 8; j++)
    begin : g_notify
        if (j < NUM_CHANNELS)
        begin : g_have
            assign notify_w[j] = notify_vec[j];
        end
        else
        begin : g_none
            assign notify_w[j] = 1'b0;
        end
    end

    assign ch_valid    = ({1'b0, item.channel_num} < (CH_NUM_W+1)'(NUM_CHANNELS));
    assign claimed_sel = |(claimed_reg & sel);
    assign next_b_sel  = |(next_b_reg & sel);
    assign busy_sel    = next_b_sel ? |(run_b_reg & sel) : |(run_a_reg & sel);

    assign do_load     = (item.operation == OP_START) && ch_valid && claimed_sel && !busy_sel;
    assign do_claim    = (item.operation == OP_REQUEST) && ch_valid && !claimed_sel;
    assign do_release  = (item.operation == OP_RELEASE) && ch_valid;
    assign do_complete = (item.operation == OP_COMPLETE);

    always_comb
    begin
        claimed_next = claimed_reg;
        handler_next = handler_reg;
        next_b_next  = next_b_reg;
        run_a_next   = run_a_reg;
        run_b_next   = run_b_reg;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (do_complete)
            begin
                run_a_next[i] = run_a_reg[i] & ~done_a[i];
                run_b_next[i] = run_b_reg[i] & ~done_b[i];
            end
            if (sel[i] && do_load)
            begin
                if (next_b_reg[i])
                begin
                    run_b_next[i] = 1'b1;
                end
                else
                begin
                    run_a_next[i] = 1'b1;
                end
                next_b_next[i] = ~next_b_reg[i];
            end
            if (sel[i] && do_claim)
            begin
                claimed_next[i] = 1'b1;
                handler_next[i] = item.handler_given;
                next_b_next[i]  = 1'b0;
                run_a_next[i]   = 1'b0;
                run_b_next[i]   = 1'b0;
            end
            if (sel[i] && do_release)
            begin
                claimed_next[i] = 1'b0;
                handler_next[i] = 1'b0;
                next_b_next[i]  = 1'b0;
                run_a_next[i]   = 1'b0;
                run_b_next[i]   = 1'b0;
            end
        end
    end

    assign free_claimed = |(claimed_next & sel);
    assign free_a       = !(|(run_a_next & sel));
    assign free_b       = !(|(run_b_next & sel));

    always_comb
    begin
        res = '0;
        res.result_code = RC_OK;
        case (item.operation)
            OP_START:
            begin
                if (!ch_valid)
                begin
                    res.result_code = RC_INVALID;
                end
                else if (!claimed_sel)
                begin
                    res.result_code = RC_NOT_REQ;
                end
                else if (busy_sel)
                begin
                    res.result_code = RC_BUSY;
                end
                else
                begin
                    res.descriptor_valid = 1'b1;
                    res.loaded_buffer    = next_b_sel;
                    res.out_source       = item.source_addr;
                    res.out_dest         = item.dest_addr;
                    res.out_count        = item.byte_count;
                end
            end
            OP_COMPLETE:
            begin
                res.notify_mask = notify_w;
            end
            OP_REQUEST:
            begin
                if (!ch_valid)
                begin
                    res.result_code = RC_INVALID;
                end
                else if (claimed_sel)
                begin
                    res.result_code = RC_BUSY;
                end
                else
                begin
                    res.control_valid = 1'b1;
                    res.control_word  = (32'(item.adjust_value) << ADJ_SHIFT)
                                        | item.control_flags;
                end
            end
            OP_RELEASE:
            begin
                if (!ch_valid)
                begin
                    res.result_code = RC_INVALID;
                end
            end
            default:
            begin
                res.result_code = RC_OK;
            end
        endcase
        res.free_buffers = free_claimed ? ({1'b0, free_a} + {1'b0, free_b}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            claimed_reg <= '0;
            handler_reg <= '0;
            next_b_reg  <= '0;
            run_a_reg   <= '0;
            run_b_reg   <= '0;
        end
        else if (fire)
        begin
            claimed_reg <= claimed_next;
            handler_reg <= handler_next;
            next_b_reg  <= next_b_next;
            run_a_reg   <= run_a_next;
            run_b_reg   <= run_b_next;
        end
    end

    // A channel that is not claimed keeps no handler, no toggle and no busy buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (handler_reg & ~claimed_reg) == '0)
        else $error("Handler recorded on an unclaimed channel.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((run_a_reg | run_b_reg | next_b_reg) & ~claimed_reg) == '0)
        else $error("Buffer state held on an unclaimed channel.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && do_load) |=> (claimed_reg != '0))
        else $error("Buffer loaded while no channel is claimed.");

endmodule

`default_nettype wire

@@ rtl/dppcm_out_stage.sv @@
// Result register that holds one response beat until the receiver takes it.
`default_nettype none

module dppcm_out_stage
    import dppcm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    fire,
    input  wire result_t res,
    output logic         take,
    output logic         rsp_valid,
    input  wire logic    rsp_ready,
    output result_t      rsp_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign take      = !valid_reg || rsp_ready;
    assign rsp_valid = valid_reg;
    assign rsp_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> take)
        else $error("Engine fired while the result register was full.");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !(res_reg.descriptor_valid && res_reg.control_valid))
        else $error("Response carries both a descriptor and a control word.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (res_reg.descriptor_valid || res_reg.control_valid))
        |-> (res_reg.result_code == RC_OK))
        else $error("Descriptor or control word issued with an error code.");

endmodule

`default_nettype wire

@@ rtl/dma_ping_pong_channel_manager.sv @@
// Ping-pong DMA channel manager: keeps double-buffer bookkeeping for each channel.
//
// The cmd channel takes one beat per operation: start transfer, completion status,
// request channel or release channel. The rsp channel returns exactly one beat per
// command, in order, carrying the result code, the loaded descriptor, the channel
// control word, the free-buffer count of the addressed channel and the notify mask.
// A command sits in an input register while the channel state is read and updated,
// and its response is then registered in the result register, which presents it
// on rsp until the receiver takes it. One command is accepted in every cycle while
// rsp ready stays high; the single state update per cycle in the engine sets that
// rate, and each command sees the state left by the one before it.
// Reset frees all channels: none claimed, no handlers, both buffers idle and buffer A
// expected next; no response is pending. When the receiver holds rsp ready low, the
// response waits in its register, one more command waits in the input register, and
// cmd ready then drops until the response is taken.
`default_nettype none

module dma_ping_pong_channel_manager
    import dppcm_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    dppcm_cmd_if.sink    cmd,
    dppcm_rsp_if.source  rsp
);

    item_t   cmd_item;
    item_t   item;
    result_t res;
    result_t rsp_res;
    logic    take;
    logic    fire;

    assign cmd_item.operation     = op_t'(cmd.operation);
    assign cmd_item.channel_num   = cmd.channel_num;
    assign cmd_item.source_addr   = cmd.source_addr;
    assign cmd_item.dest_addr     = cmd.dest_addr;
    assign cmd_item.byte_count    = cmd.byte_count;
    assign cmd_item.done_status   = cmd.done_status;
    assign cmd_item.adjust_value  = cmd.adjust_value;
    assign cmd_item.control_flags = cmd.control_flags;
    assign cmd_item.handler_given = cmd.handler_given;

    dppcm_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .cmd_item  (cmd_item),
        .take      (take),
        .fire      (fire),
        .item      (item)
    );

    dppcm_engine #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .res   (res)
    );

    dppcm_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res       (res),
        .take      (take),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_res   (rsp_res)
    );

    assign rsp.result_code      = rsp_res.result_code;
    assign rsp.descriptor_valid = rsp_res.descriptor_valid;
    assign rsp.loaded_buffer    = rsp_res.loaded_buffer;
    assign rsp.out_source       = rsp_res.out_source;
    assign rsp.out_dest         = rsp_res.out_dest;
    assign rsp.out_count        = rsp_res.out_count;
    assign rsp.control_valid    = rsp_res.control_valid;
    assign rsp.control_word     = rsp_res.control_word;
    assign rsp.free_buffers     = rsp_res.free_buffers;
    assign rsp.notify_mask      = rsp_res.notify_mask;

endmodule

`default_nettype wire
